[sv/block_residency_table_top_assert.svh]
// Assertion macros used by the block residency table top module.
`ifndef BLOCK_RESIDENCY_TABLE_TOP_ASSERT_SVH
`define BLOCK_RESIDENCY_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BRT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BRT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

// Delayed implication, disabled while in reset.
`define BRT_ASSERT_LAT3(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> ##3 (cons)) else $error(msg);

`endif

[sv/brt_pkg.sv]
// Types, sizes and operation codes of the block residency table.
package brt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 32;
  localparam int LIVE_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int FUNC_W     = 3;
  localparam int KEY_W      = 64;
  localparam int ADDR_W     = 64;
  localparam int STAMP_W    = 64;
  localparam int RES_W      = 2;
  localparam int TOTAL_W    = 32;
  localparam int LIVE_OUT_W = 7;

  localparam logic [FUNC_W-1:0] FN_LOOKUP    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_MARK_LOAD = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MARK_DRAM = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MARK_HBM  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RELEASE   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_ERASE     = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd6;

  localparam logic [RES_W-1:0] RES_NONE    = 2'd0;
  localparam logic [RES_W-1:0] RES_LOADING = 2'd1;
  localparam logic [RES_W-1:0] RES_DRAM    = 2'd2;
  localparam logic [RES_W-1:0] RES_HBM     = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  blk_key;
    logic [ADDR_W-1:0] location;
  } brt_in_t;

  typedef struct packed {
    logic [KEY_W-1:0]      entry_id;
    logic [RES_W-1:0]      residency;
    logic [ADDR_W-1:0]     dram_location;
    logic [ADDR_W-1:0]     device_location;
    logic [STAMP_W-1:0]    access_stamp;
    logic [TOTAL_W-1:0]    access_total;
    logic [TOTAL_W-1:0]    reference_total;
    logic [LIVE_OUT_W-1:0] live_entries;
    logic                  table_full;
  } brt_out_t;

  // Per-slot payload, everything but the key.
  typedef struct packed {
    logic [RES_W-1:0]      residency;
    logic [ADDR_W-1:0]     dram;
    logic [ADDR_W-1:0]     device;
    logic [STAMP_W-1:0]    stamp;
    logic [COUNT_BITS-1:0] accesses;
    logic [COUNT_BITS-1:0] references;
  } brt_entry_t;

  localparam int ENTRY_W = $bits(brt_entry_t);

  // Key-side update for one beat.
  typedef struct packed {
    logic                     alloc;
    logic                     drop;
    logic                     wipe;
    logic [TABLE_ENTRIES-1:0] target_oh;
    logic [KEY_W-1:0]         key;
  } brt_key_cmd_t;

endpackage

[sv/brt_match.sv]
// Key cells with valid bits, parallel match, free-slot pick and live count.
module brt_match (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [brt_pkg::KEY_W-1:0]          probe_key,
  input  brt_pkg::brt_key_cmd_t              cmd,
  output logic [brt_pkg::TABLE_ENTRIES-1:0]  match_oh,
  output logic [brt_pkg::TABLE_ENTRIES-1:0]  free_oh,
  output logic [brt_pkg::LIVE_W-1:0]         live_nxt
);
  import brt_pkg::*;

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [TABLE_ENTRIES-1:0] valid_nxt;
  logic [KEY_W-1:0]         key_r [TABLE_ENTRIES];
  logic [LIVE_W-1:0]        cnt_r;
  logic [LIVE_W-1:0]        cnt_nxt;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_oh[i] = valid_r[i] && (key_r[i] == probe_key);
    end
  end

  // Lowest clear valid bit; zero when every slot is taken.
  assign free_oh = ~valid_r & (valid_r + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});

  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    if (cmd.wipe) begin
      valid_nxt = '0;
      cnt_nxt   = '0;
    end else if (cmd.alloc) begin
      valid_nxt = valid_r | cmd.target_oh;
      cnt_nxt   = cnt_r + LIVE_W'(1);
    end else if (cmd.drop) begin
      valid_nxt = valid_r & ~cmd.target_oh;
      cnt_nxt   = cnt_r - LIVE_W'(1);
    end
  end

  assign live_nxt = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cmd.alloc && cmd.target_oh[i]) begin
        key_r[i] <= cmd.key;
      end
    end
  end

endmodule

[sv/brt_store.sv]
// Slot payload memory: registered read, same-edge write passed through to the read.
module brt_store (
  input  logic                          clk,
  input  logic [brt_pkg::IDX_W-1:0]     rd_idx,
  input  logic                          wr_en,
  input  logic [brt_pkg::IDX_W-1:0]     wr_idx,
  input  brt_pkg::brt_entry_t           wr_entry,
  output brt_pkg::brt_entry_t           rd_entry
);
  import brt_pkg::*;

  logic [ENTRY_W-1:0] slot_r [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_q_r;
  logic [ENTRY_W-1:0] byp_q_r;
  logic               byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_idx] <= wr_entry;
    end
    rd_q_r  <= slot_r[rd_idx];
    // The array read misses a write on the same edge; hold that payload instead.
    byp_r   <= wr_en && (wr_idx == rd_idx);
    byp_q_r <= wr_entry;
  end

  assign rd_entry = byp_r ? byp_q_r : rd_q_r;

endmodule

[sv/block_residency_table_top.sv]
// Block residency table: one operation per cycle, with a registered result.
// The start beat is captured in an input register and matched
// against all 64 key cells at once; valid bits, keys, the live count and the
// step counter update at the end of that cycle, and the payload of the
// matched or newly taken slot is read from a memory with a registered read.
// In the next cycle the payload is updated and written back and the result
// register is loaded, so out_strobe is high for exactly one cycle. A payload
// written back on the same edge as the next beat's read is passed straight
// through, so beats may follow with no gap. The receiver cannot stall
// results, and none is needed: busy is high only while rst_n is low and for
// the cycle after, so a new start may be given on every cycle. The table and
// step counter are empty after reset with no clearing pass.
`include "block_residency_table_top_assert.svh"

module block_residency_table_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  brt_pkg::brt_in_t  in_data,
  output logic              out_strobe,
  output brt_pkg::brt_out_t out_data
);
  import brt_pkg::*;

  logic                     busy_r;
  logic                     in_vld_r;
  brt_in_t                  in_q_r;
  logic [STAMP_W-1:0]       step_r;
  logic [STAMP_W-1:0]       step_nxt;
  logic                     s2_vld_r;
  brt_in_t                  s2_q_r;
  logic                     s2_hit_r;
  logic                     s2_full_r;
  logic                     s2_touch_r;
  logic                     s2_show_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic [STAMP_W-1:0]       s2_stamp_r;
  logic [LIVE_W-1:0]        s2_live_r;
  logic                     out_strobe_r;
  brt_out_t                 out_q_r;
  brt_out_t                 out_nxt;

  logic [TABLE_ENTRIES-1:0] match_oh;
  logic [TABLE_ENTRIES-1:0] free_oh;
  logic [IDX_W-1:0]         tgt_idx;
  logic [LIVE_W-1:0]        live_nxt;
  brt_key_cmd_t             key_cmd;
  brt_entry_t               rd_entry;
  brt_entry_t               cur;
  brt_entry_t               upd;
  brt_entry_t               rep;

  logic in_acc;
  logic hit;
  logic room;
  logic is_touch;
  logic is_rel;
  logic is_era;
  logic is_clr;
  logic full;
  logic touched;
  logic show;
  logic wr_en;

  assign in_acc = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      in_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      step_r       <= '0;
    end else begin
      busy_r       <= 1'b0;
      in_vld_r     <= in_acc;
      s2_vld_r     <= in_vld_r;
      out_strobe_r <= s2_vld_r;
      step_r       <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_q_r <= in_data;
    end
    if (in_vld_r) begin
      s2_q_r     <= in_q_r;
      s2_hit_r   <= hit;
      s2_full_r  <= full;
      s2_touch_r <= touched;
      s2_show_r  <= show;
      s2_idx_r   <= tgt_idx;
      s2_stamp_r <= step_r + STAMP_W'(1);
      s2_live_r  <= live_nxt;
    end
    if (s2_vld_r) begin
      out_q_r <= out_nxt;
    end
  end

  brt_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .probe_key (in_q_r.blk_key),
    .cmd       (key_cmd),
    .match_oh  (match_oh),
    .free_oh   (free_oh),
    .live_nxt  (live_nxt)
  );

  brt_store u_store (
    .clk      (clk),
    .rd_idx   (tgt_idx),
    .wr_en    (wr_en),
    .wr_idx   (s2_idx_r),
    .wr_entry (upd),
    .rd_entry (rd_entry)
  );

  // Match stage: decode, key-side update and payload read address.
  assign hit      = |match_oh;
  assign room     = |free_oh;
  assign is_touch = (in_q_r.func <= FN_MARK_HBM);
  assign is_rel   = (in_q_r.func == FN_RELEASE);
  assign is_era   = (in_q_r.func == FN_ERASE);
  assign is_clr   = (in_q_r.func == FN_CLEAR);

  assign full    = is_touch && !hit && !room;
  assign touched = in_vld_r && ((is_touch && (hit || room)) || (is_rel && hit));
  assign show    = touched || (is_era && hit);

  assign step_nxt = touched ? step_r + STAMP_W'(1) : step_r;

  always_comb begin
    key_cmd.alloc     = in_vld_r && is_touch && !hit && room;
    key_cmd.drop      = in_vld_r && is_era && hit;
    key_cmd.wipe      = in_vld_r && is_clr;
    key_cmd.target_oh = hit ? match_oh : free_oh;
    key_cmd.key       = in_q_r.blk_key;
  end

  always_comb begin
    tgt_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (key_cmd.target_oh[i]) begin
        tgt_idx = tgt_idx | IDX_W'(i);
      end
    end
  end

  // Update stage: a fresh slot starts from all-zero fields.
  assign cur = s2_hit_r ? rd_entry : '0;

  always_comb begin
    upd       = cur;
    upd.stamp = s2_stamp_r;
    case (s2_q_r.func)
      FN_LOOKUP: begin
        if (cur.accesses != COUNT_MAX) begin
          upd.accesses = cur.accesses + COUNT_BITS'(1);
        end
        if (cur.references != COUNT_MAX) begin
          upd.references = cur.references + COUNT_BITS'(1);
        end
      end
      FN_MARK_LOAD: begin
        upd.residency = RES_LOADING;
      end
      FN_MARK_DRAM: begin
        upd.residency = RES_DRAM;
        upd.dram      = s2_q_r.location;
      end
      FN_MARK_HBM: begin
        upd.residency = RES_HBM;
        upd.device    = s2_q_r.location;
      end
      FN_RELEASE: begin
        if (cur.references != '0) begin
          upd.references = cur.references - COUNT_BITS'(1);
        end
      end
      default: begin
        upd = cur;
      end
    endcase
  end

  assign wr_en = s2_vld_r && s2_touch_r;

  assign rep = s2_show_r ? (s2_touch_r ? upd : cur) : '0;

  always_comb begin
    out_nxt.entry_id        = (s2_q_r.func == FN_CLEAR) ? '0 : s2_q_r.blk_key;
    out_nxt.residency       = rep.residency;
    out_nxt.dram_location   = rep.dram;
    out_nxt.device_location = rep.device;
    out_nxt.access_stamp    = rep.stamp;
    out_nxt.access_total    = TOTAL_W'(rep.accesses);
    out_nxt.reference_total = TOTAL_W'(rep.references);
    out_nxt.live_entries    = LIVE_OUT_W'(s2_live_r);
    out_nxt.table_full      = s2_full_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_q_r;

  `BRT_ASSERT_IMP(a_match_unique, clk, rst_n, 1'b1, $onehot0(match_oh), "key matches more than one slot")
  `BRT_ASSERT_IMP(a_full_when_packed, clk, rst_n, out_strobe_r && out_q_r.table_full, out_q_r.live_entries == LIVE_OUT_W'(TABLE_ENTRIES), "table full flagged with free slots")
  `BRT_ASSERT_NXT(a_step_advance, clk, rst_n, touched, step_r == $past(step_r) + STAMP_W'(1), "step counter did not advance on a touch")
  `BRT_ASSERT_LAT3(a_result_latency, clk, rst_n, start && !busy, out_strobe, "accepted beat produced no result")

endmodule

[bench/tb_block_residency_table_top.sv]
// Self-checking bench for the block residency table: shadow table prediction, bursty driver.
module tb_block_residency_table_top;
  import brt_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 1300;
  localparam int POOL_SIZE    = 80;
  localparam int IDLE_LIMIT   = 1000;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_ALT0 = 64'h5555_5555_5555_5555;
  localparam logic [KEY_W-1:0] KEY_ALT1 = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct {
    brt_in_t beat;
    bit      drain_first;
  } pending_op_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  brt_in_t  in_data = '0;
  logic     out_strobe;
  brt_out_t out_data;

  pending_op_t op_queue[$];
  brt_out_t    awaited_entries[$];
  bit          beat_taken = 1'b0;
  int          burst_left = 8;
  int          gap_left = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          queued = 0;

  // Shadow copy of the table
  bit                 sh_valid [TABLE_ENTRIES];
  logic [KEY_W-1:0]   sh_key [TABLE_ENTRIES];
  brt_entry_t         sh_slot [TABLE_ENTRIES];
  logic [STAMP_W-1:0] sh_step = '0;
  int                 sh_live = 0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  block_residency_table_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] pick_location();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return rand64();
  endfunction

  function automatic brt_out_t slot_view(int s);
    brt_out_t r;
    r = '0;
    r.entry_id        = sh_key[s];
    r.residency       = sh_slot[s].residency;
    r.dram_location   = sh_slot[s].dram;
    r.device_location = sh_slot[s].device;
    r.access_stamp    = sh_slot[s].stamp;
    r.access_total    = sh_slot[s].accesses[TOTAL_W-1:0];
    r.reference_total = sh_slot[s].references[TOTAL_W-1:0];
    return r;
  endfunction

  // Apply one beat to the shadow table and return the entry it reports.
  function automatic brt_out_t shadow_apply(brt_in_t beat);
    brt_out_t r;
    int hit;
    int s;
    hit = -1;
    for (s = 0; s < TABLE_ENTRIES; s++)
      if (hit < 0 && sh_valid[s] && sh_key[s] == beat.blk_key) hit = s;
    r = '0;
    r.entry_id = beat.blk_key;
    case (beat.func)
      FN_LOOKUP, FN_MARK_LOAD, FN_MARK_DRAM, FN_MARK_HBM: begin
        // new id takes the lowest free slot
        if (hit < 0) begin
          for (s = 0; s < TABLE_ENTRIES; s++) begin
            if (hit < 0 && !sh_valid[s]) begin
              hit = s;
              sh_valid[s] = 1'b1;
              sh_key[s] = beat.blk_key;
              sh_slot[s] = '0;
              sh_live++;
            end
          end
        end
        if (hit < 0) begin
          r.table_full = 1'b1;
        end else begin
          sh_step = sh_step + 1'b1;
          sh_slot[hit].stamp = sh_step;
          case (beat.func)
            FN_LOOKUP: begin
              if (sh_slot[hit].accesses != COUNT_MAX)
                sh_slot[hit].accesses = sh_slot[hit].accesses + 1'b1;
              if (sh_slot[hit].references != COUNT_MAX)
                sh_slot[hit].references = sh_slot[hit].references + 1'b1;
            end
            FN_MARK_LOAD: sh_slot[hit].residency = RES_LOADING;
            FN_MARK_DRAM: begin
              sh_slot[hit].residency = RES_DRAM;
              sh_slot[hit].dram = beat.location;
            end
            FN_MARK_HBM: begin
              sh_slot[hit].residency = RES_HBM;
              sh_slot[hit].device = beat.location;
            end
            default: ;
          endcase
          r = slot_view(hit);
        end
      end
      FN_RELEASE: begin
        if (hit >= 0) begin
          if (sh_slot[hit].references != '0)
            sh_slot[hit].references = sh_slot[hit].references - 1'b1;
          sh_step = sh_step + 1'b1;
          sh_slot[hit].stamp = sh_step;
          r = slot_view(hit);
        end
      end
      FN_ERASE: begin
        if (hit >= 0) begin
          r = slot_view(hit);
          sh_valid[hit] = 1'b0;
          sh_live--;
        end
      end
      FN_CLEAR: begin
        for (s = 0; s < TABLE_ENTRIES; s++) sh_valid[s] = 1'b0;
        sh_live = 0;
        r.entry_id = '0;
      end
      default: ;
    endcase
    r.live_entries = sh_live[LIVE_OUT_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic queue_beat(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                            input logic [ADDR_W-1:0] loc, input bit drain);
    pending_op_t p;
    p.beat.func = func;
    p.beat.blk_key = key;
    p.beat.location = loc;
    p.drain_first = drain;
    op_queue.push_back(p);
    queued++;
  endtask

  // Clear, then create fresh ids until past capacity so new ids get refused.
  task automatic queue_fill_run();
    int k;
    queue_beat(FN_CLEAR, rand64(), pick_location(), 1'b0);
    for (k = 0; k < TABLE_ENTRIES + 4; k++)
      queue_beat(FN_LOOKUP + FUNC_W'($urandom_range(0, 3)), rand64(), pick_location(), 1'b0);
  endtask

  task automatic queue_random_op();
    int roll;
    logic [FUNC_W-1:0] f;
    logic [KEY_W-1:0] key;
    roll = $urandom_range(0, 99);
    if (roll < 36)      f = FN_LOOKUP;
    else if (roll < 44) f = FN_MARK_LOAD;
    else if (roll < 52) f = FN_MARK_DRAM;
    else if (roll < 60) f = FN_MARK_HBM;
    else if (roll < 78) f = FN_RELEASE;
    else if (roll < 98) f = FN_ERASE;
    else if (roll < 99) f = FN_CLEAR;
    else                f = FN_UNUSED;
    if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else key = rand64();
    queue_beat(f, key, pick_location(), $urandom_range(0, 99) == 0);
  endtask

  initial begin : stimulus
    int k;
    for (k = 0; k < POOL_SIZE; k++) key_pool[k] = rand64();
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;

    // Absent ids first, then one entry walked through every operation
    queue_beat(FN_RELEASE,   KEY_ONES, '0,       1'b0);
    queue_beat(FN_ERASE,     KEY_ONES, KEY_ONES, 1'b0);
    queue_beat(FN_LOOKUP,    '0,       '0,       1'b0);
    queue_beat(FN_LOOKUP,    '0,       KEY_ONES, 1'b0);
    queue_beat(FN_MARK_LOAD, '0,       KEY_ALT1, 1'b0);
    queue_beat(FN_MARK_DRAM, '0,       KEY_ONES, 1'b0);
    queue_beat(FN_MARK_HBM,  '0,       KEY_ALT0, 1'b0);
    // third release hits the zero floor
    queue_beat(FN_RELEASE,   '0,       '0,       1'b0);
    queue_beat(FN_RELEASE,   '0,       '0,       1'b0);
    queue_beat(FN_RELEASE,   '0,       '0,       1'b0);
    // marks that create their entry
    queue_beat(FN_MARK_HBM,  KEY_ONES, KEY_ONES, 1'b0);
    queue_beat(FN_MARK_DRAM, KEY_ALT1, KEY_ALT1, 1'b0);
    queue_beat(FN_MARK_LOAD, KEY_ALT0, '0,       1'b0);
    queue_beat(FN_RELEASE,   KEY_ALT0, '0,       1'b0);
    queue_beat(FN_LOOKUP,    KEY_ONES, '0,       1'b0);
    queue_beat(FN_ERASE,     '0,       '0,       1'b0);
    queue_beat(FN_LOOKUP,    '0,       '0,       1'b0);
    queue_beat(FN_UNUSED,    KEY_ALT1, KEY_ALT0, 1'b0);
    queue_beat(FN_CLEAR,     KEY_ONES, KEY_ONES, 1'b1);
    queue_beat(FN_LOOKUP,    KEY_ONES, '0,       1'b0);
    queue_beat(FN_RELEASE,   KEY_ONES, '0,       1'b0);
    queue_beat(FN_ERASE,     KEY_ONES, '0,       1'b0);
    queue_beat(FN_ERASE,     KEY_ONES, '0,       1'b0);

    k = queued;
    queue_fill_run();
    while (queued < k + RANDOM_ITEMS) begin
      if ($urandom_range(0, 149) == 0) queue_fill_run();
      else queue_random_op();
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (op_queue.size() != 0 || awaited_entries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_block_residency_table_top: done, clean");
    end else begin
      $display("tb_block_residency_table_top: done, errors");
    end
    $finish;
  end

  // Driver: bursts of beats with random gaps, optional drain before a beat.
  always @(negedge clk) begin
    if (beat_taken) begin
      beat_taken = 1'b0;
      op_queue.delete(0);
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 16);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      end
    end
    if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (op_queue.size() == 0 ||
                 (op_queue[0].drain_first && awaited_entries.size() != 0)) begin
      start <= 1'b0;
    end else begin
      start   <= 1'b1;
      in_data <= op_queue[0].beat;
    end
  end

  // Monitor: check the result beat, then predict the beat accepted at this edge.
  always @(posedge clk) begin
    brt_out_t want;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (awaited_entries.size() == 0) begin
          flag_mismatch("unexpected result, entry_id", out_data.entry_id, '0);
        end else begin
          want = awaited_entries.pop_front();
          if (out_data.entry_id !== want.entry_id)
            flag_mismatch("entry_id", out_data.entry_id, want.entry_id);
          if (out_data.residency !== want.residency)
            flag_mismatch("residency", out_data.residency, want.residency);
          if (out_data.dram_location !== want.dram_location)
            flag_mismatch("dram_location", out_data.dram_location, want.dram_location);
          if (out_data.device_location !== want.device_location)
            flag_mismatch("device_location", out_data.device_location,
                          want.device_location);
          if (out_data.access_stamp !== want.access_stamp)
            flag_mismatch("access_stamp", out_data.access_stamp, want.access_stamp);
          if (out_data.access_total !== want.access_total)
            flag_mismatch("access_total", out_data.access_total, want.access_total);
          if (out_data.reference_total !== want.reference_total)
            flag_mismatch("reference_total", out_data.reference_total,
                          want.reference_total);
          if (out_data.live_entries !== want.live_entries)
            flag_mismatch("live_entries", out_data.live_entries, want.live_entries);
          if (out_data.table_full !== want.table_full)
            flag_mismatch("table_full", out_data.table_full, want.table_full);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        awaited_entries.push_back(shadow_apply(in_data));
        beat_taken = 1'b1;
      end
    end
  end

  // Watchdog: end the run after a long stretch with no beat in either direction.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, awaited_entries.size());
      $display("tb_block_residency_table_top: done, errors");
      $finish;
    end
  end

endmodule
